// ===== rtl/days_between_dates_top_macros.svh =====
// Assertion helpers shared by the RTL. Every check is sampled on the rising
// clock edge and is held off while the asynchronous reset is asserted.
`ifndef DAYS_BETWEEN_DATES_TOP_MACROS_SVH
`define DAYS_BETWEEN_DATES_TOP_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define DBD_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define DBD_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/dbd_pkg.sv =====
package dbd_pkg;

	localparam int STEP_BITS = 3;
	typedef logic [STEP_BITS-1:0] step_t;

	// Program steps. The last step falls through to the first one.
	localparam step_t S_IDLE   = 3'd0;
	localparam step_t S_MOD400 = 3'd1;
	localparam step_t S_LODOY  = 3'd2;
	localparam step_t S_YEARS  = 3'd3;
	localparam step_t S_HIDOY  = 3'd4;
	localparam step_t S_ABS    = 3'd5;
	localparam step_t S_SAT    = 3'd6;
	localparam step_t S_EMIT   = 3'd7;

	typedef logic [2:0] cond_t;

	localparam cond_t COND_NEXT  = 3'd0;
	localparam cond_t COND_IDLE  = 3'd1;
	localparam cond_t COND_GE400 = 3'd2;
	localparam cond_t COND_MORE  = 3'd3;
	localparam cond_t COND_BUSY  = 3'd4;

	localparam int COUNT_BITS    = 21;
	localparam int DAY_BITS      = 5;
	localparam int MONTH_BITS    = 4;
	localparam int DOY_BITS      = 9;
	localparam int LEAP_CYCLE    = 400;
	localparam int CENTURY       = 100;
	localparam int DAYS_PER_YEAR = 365;
	localparam logic [COUNT_BITS-1:0] DAY_COUNT_MAX = '1;

	// Horizontal control word: one enable per datapath action, plus the
	// jump condition and target. Without a jump the step counter advances.
	typedef struct packed {
		logic  load;
		logic  sub400;
		logic  sub_lo_doy;
		logic  add_year;
		logic  add_hi_doy;
		logic  negate;
		logic  saturate;
		logic  emit;
		cond_t cond;
		step_t jmp;
	} ctrl_t;

	function automatic ctrl_t ucode(step_t s);
		ctrl_t c;
		c = '0;
		c.jmp = s;
		unique case (s)
			S_IDLE: begin
				c.load = 1'b1;
				c.cond = COND_IDLE;
			end
			S_MOD400: begin
				c.sub400 = 1'b1;
				c.cond = COND_GE400;
			end
			S_LODOY: begin
				c.sub_lo_doy = 1'b1;
			end
			S_YEARS: begin
				c.add_year = 1'b1;
				c.cond = COND_MORE;
			end
			S_HIDOY: begin
				c.add_hi_doy = 1'b1;
			end
			S_ABS: begin
				c.negate = 1'b1;
			end
			S_SAT: begin
				c.saturate = 1'b1;
			end
			S_EMIT: begin
				c.emit = 1'b1;
				c.cond = COND_BUSY;
			end
		endcase
		return c;
	endfunction

	// Day of the year. Months outside 1..12 add no offset.
	function automatic logic [DOY_BITS-1:0] day_of_year(logic [DAY_BITS-1:0] day,
			logic [MONTH_BITS-1:0] month, logic leap);
		logic [DOY_BITS-1:0] off;
		logic                bump;
		unique case (month)
			4'd2:    off = 9'd31;
			4'd3:    off = 9'd59;
			4'd4:    off = 9'd90;
			4'd5:    off = 9'd120;
			4'd6:    off = 9'd151;
			4'd7:    off = 9'd181;
			4'd8:    off = 9'd212;
			4'd9:    off = 9'd243;
			4'd10:   off = 9'd273;
			4'd11:   off = 9'd304;
			4'd12:   off = 9'd334;
			default: off = 9'd0;
		endcase
		bump = leap && (month >= 4'd3) && (month <= 4'd12);
		return off + DOY_BITS'(day) + DOY_BITS'(bump);
	endfunction

endpackage

// ===== rtl/days_between_dates_top.sv =====
// A request runs through the steps MOD400 (repeated while the year residue is 400 or
// more), LODOY, YEARS (one year per cycle up to the later year), HIDOY, ABS, SAT and EMIT.
// One request is in flight at a time; the next is taken in the idle step that follows the
// hand-off of the result to the output register, and EMIT waits while that register is full.
// Reset (arst_n low, asynchronous) returns the sequencer to its idle step and drops
// res_valid; datapath registers are not reset.
`include "days_between_dates_top_macros.svh"

module days_between_dates_top #(
	parameter int YEAR_BITS = 12
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   req_valid,
	output logic                                   req_ready,
	input  logic [dbd_pkg::DAY_BITS-1:0]           first_day,
	input  logic [dbd_pkg::MONTH_BITS-1:0]         first_month,
	input  logic [YEAR_BITS-1:0]                   first_year,
	input  logic [dbd_pkg::DAY_BITS-1:0]           second_day,
	input  logic [dbd_pkg::MONTH_BITS-1:0]         second_month,
	input  logic [YEAR_BITS-1:0]                   second_year,
	output logic                                   res_valid,
	input  logic                                   res_ready,
	output logic [dbd_pkg::COUNT_BITS-1:0]         day_count
);

	// Room for the full year span times 366 plus a sign bit.
	localparam int ACC_BITS = YEAR_BITS + 10;
	localparam int R_BITS   = (YEAR_BITS > 9) ? YEAR_BITS : 9;
	localparam int CMP_BITS = (ACC_BITS > dbd_pkg::COUNT_BITS) ? ACC_BITS
		: dbd_pkg::COUNT_BITS;

	dbd_pkg::step_t step_q;
	dbd_pkg::step_t step_d;
	dbd_pkg::ctrl_t ctrl;

	logic [YEAR_BITS-1:0]              year_q;
	logic [YEAR_BITS-1:0]              end_q;
	logic [R_BITS-1:0]                 r_q;
	logic [ACC_BITS-1:0]               acc_q;
	logic [dbd_pkg::DAY_BITS-1:0]      lo_day_q;
	logic [dbd_pkg::MONTH_BITS-1:0]    lo_month_q;
	logic [dbd_pkg::DAY_BITS-1:0]      hi_day_q;
	logic [dbd_pkg::MONTH_BITS-1:0]    hi_month_q;
	logic [dbd_pkg::COUNT_BITS-1:0]    cnt_q;
	logic [dbd_pkg::COUNT_BITS-1:0]    day_count_q;
	logic                              res_valid_q;

	logic                              ge400;
	logic                              more;
	logic                              leap;
	logic                              out_free;
	logic                              taken;
	logic                              swap;
	logic [CMP_BITS-1:0]               acc_ext;
	logic [dbd_pkg::COUNT_BITS-1:0]    sat_cnt;

	assign ctrl = dbd_pkg::ucode(step_q);

	assign ge400    = r_q >= R_BITS'(dbd_pkg::LEAP_CYCLE);
	assign more     = year_q != end_q;
	assign out_free = !res_valid_q || res_ready;
	assign swap     = first_year > second_year;

	// r_q holds the current year modulo 400 once the reduction loop is done, so a
	// century year is one where it reads 100, 200 or 300.
	assign leap = (year_q[1:0] == 2'b00)
		&& (r_q != R_BITS'(dbd_pkg::CENTURY))
		&& (r_q != R_BITS'(2 * dbd_pkg::CENTURY))
		&& (r_q != R_BITS'(3 * dbd_pkg::CENTURY));

	assign acc_ext = CMP_BITS'(acc_q);
	assign sat_cnt = (acc_ext > CMP_BITS'(dbd_pkg::DAY_COUNT_MAX)) ? dbd_pkg::DAY_COUNT_MAX
		: acc_ext[dbd_pkg::COUNT_BITS-1:0];

	always_comb begin
		unique case (ctrl.cond)
			dbd_pkg::COND_IDLE:  taken = !req_valid;
			dbd_pkg::COND_GE400: taken = ge400;
			dbd_pkg::COND_MORE:  taken = more;
			dbd_pkg::COND_BUSY:  taken = !out_free;
			default:             taken = 1'b0;
		endcase
		step_d = taken ? ctrl.jmp : step_q + dbd_pkg::STEP_BITS'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= dbd_pkg::S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			step_q <= step_d;
			if (ctrl.emit && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load && req_valid) begin
			year_q     <= swap ? second_year : first_year;
			end_q      <= swap ? first_year : second_year;
			r_q        <= R_BITS'(swap ? second_year : first_year);
			lo_day_q   <= swap ? second_day : first_day;
			lo_month_q <= swap ? second_month : first_month;
			hi_day_q   <= swap ? first_day : second_day;
			hi_month_q <= swap ? first_month : second_month;
			acc_q      <= '0;
		end
		if (ctrl.sub400 && ge400) begin
			r_q <= r_q - R_BITS'(dbd_pkg::LEAP_CYCLE);
		end
		if (ctrl.sub_lo_doy) begin
			acc_q <= acc_q - ACC_BITS'(dbd_pkg::day_of_year(lo_day_q, lo_month_q, leap));
		end
		if (ctrl.add_year && more) begin
			acc_q  <= acc_q + ACC_BITS'(dbd_pkg::DAYS_PER_YEAR) + ACC_BITS'(leap);
			year_q <= year_q + YEAR_BITS'(1);
			r_q    <= (r_q == R_BITS'(dbd_pkg::LEAP_CYCLE - 1)) ? '0 : r_q + R_BITS'(1);
		end
		if (ctrl.add_hi_doy) begin
			acc_q <= acc_q + ACC_BITS'(dbd_pkg::day_of_year(hi_day_q, hi_month_q, leap));
		end
		// Only equal years can leave a negative sum.
		if (ctrl.negate && acc_q[ACC_BITS-1]) begin
			acc_q <= '0 - acc_q;
		end
		if (ctrl.saturate) begin
			cnt_q <= sat_cnt;
		end
		if (ctrl.emit && out_free) begin
			day_count_q <= cnt_q;
		end
	end

	assign req_ready = ctrl.load;
	assign res_valid = res_valid_q;
	assign day_count = day_count_q;

	`DBD_ASSERT_CLK(a_year_bound, (step_q == dbd_pkg::S_YEARS) |-> (year_q <= end_q), "year counter passed the later year")
	`DBD_ASSERT_CLK(a_mod_done, (step_q != dbd_pkg::S_IDLE && step_q != dbd_pkg::S_MOD400) |-> (r_q < R_BITS'(dbd_pkg::LEAP_CYCLE)), "year residue not reduced below 400")
	`DBD_ASSERT_NEVER(a_sum_sign, (step_q == dbd_pkg::S_SAT) && acc_q[ACC_BITS-1], "day sum negative at saturation")
	`DBD_ASSERT_CLK(a_start, (req_valid && req_ready) |=> (step_q == dbd_pkg::S_MOD400), "accepted request did not start the program")

endmodule
